@@ design/assert_macros.svh @@
// Assertion macros used by the hash dedup table top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HDT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("hdt assertion failed");
`define HDT_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("hdt forbidden condition seen");
`else
`define HDT_ASSERT(label, clk, rst_n, prop)
`define HDT_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

@@ design/hdt_pkg.sv @@
// Shared constants and types for the hash dedup table.
package hdt_pkg;

    localparam int DEF_MAX_ENTRIES = 512;
    localparam int DEF_MAX_LINKS   = 8;

    localparam int HASH_W    = 64;
    localparam int PROG_W    = 7;
    localparam int NOTE_W    = 7;
    localparam int SOUND_W   = PROG_W + NOTE_W;
    localparam int OUTCOME_W = 3;
    localparam int OIDX_W    = 9;
    localparam int OSLOT_W   = 3;
    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 16;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic REG_MATCH_DISABLED = 1'b0;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_SILENT  = 3'd0,
        OUT_NEW     = 3'd1,
        OUT_ALIAS   = 3'd2,
        OUT_DROPPED = 3'd3,
        OUT_REFUSED = 3'd4
    } t_outcome;

endpackage

@@ design/hdt_cell.sv @@
// One table entry cell: holds a hash, its sound pair and alias count, shifts on command.
module hdt_cell #(
    parameter int LC_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [hdt_pkg::HASH_W-1:0]  i_hash,
    input  logic [hdt_pkg::SOUND_W-1:0] i_sound,
    input  logic [LC_W-1:0]             i_lcnt,
    output logic [hdt_pkg::HASH_W-1:0]  o_hash,
    output logic [hdt_pkg::SOUND_W-1:0] o_sound,
    output logic [LC_W-1:0]             o_lcnt
);
    import hdt_pkg::*;

    logic [HASH_W-1:0]  r_hash;
    logic [SOUND_W-1:0] r_sound;
    logic [LC_W-1:0]    r_lcnt;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hash  <= i_hash;
            r_sound <= i_sound;
            r_lcnt  <= i_lcnt;
        end
    end

    assign o_hash  = r_hash;
    assign o_sound = r_sound;
    assign o_lcnt  = r_lcnt;

endmodule

@@ design/hash_dedup_table.sv @@
// Hash dedup table top level: ring of entry cells, search sequencer, APB and stream ports.
//
// Input stream (s_axis): one beat per sound, tdata = {note, program_req, sound_hash}.
// Output stream (m_axis): one beat per input beat, tdata = {alias_slot, entry_index,
// outcome}, in input order.
// Configuration (APB): register 0 at byte address 0, bit 0 = match_disabled.
//
// Stored entries sit in a ring of MAX_ENTRIES cells. A nonsilent item rotates the
// whole ring once past the head cell, one cell per cycle, comparing each entry in
// creation order; a hit bumps the alias count as the entry passes, and a new entry
// is dropped into the ring at the slot just past the last valid one. The rotation
// ends with every entry back at its home cell.
// A nonsilent beat reaches S_DONE through the ring rotation in S_SEARCH, a silent one or
// any after stop goes there straight from idle, and S_DONE loads the result register;
// s_axis_tready is high only in idle, so a new item is taken only once the sequencer is done with the last one.
// The result goes to an output register, so the next item is accepted while a
// result still waits; if m_axis_tready is low when a second result is ready, the
// sequencer holds it and accepts nothing more until the register drains.
// Reset clears the entry count, the stop flag, match_disabled and the output valid;
// stored entries need no clearing since only entries below the count are read.
module hash_dedup_table #(
    parameter int MAX_ENTRIES = hdt_pkg::DEF_MAX_ENTRIES,
    parameter int MAX_LINKS   = hdt_pkg::DEF_MAX_LINKS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // fields from bit 0: sound_hash[63:0], program_req[70:64], note[77:71], zero fill
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [hdt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // fields from bit 0: outcome[2:0], entry_index[11:3], alias_slot[14:12], zero fill
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [hdt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hdt_pkg::APB_AW-1:0]     paddr,
    input  logic [hdt_pkg::APB_DW-1:0]     pwdata,
    output logic [hdt_pkg::APB_DW-1:0]     prdata,
    output logic                          pready
);
    import hdt_pkg::*;
    `include "assert_macros.svh"

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int LC_W  = $clog2(MAX_LINKS + 1);
    localparam int LINK_DEPTH = MAX_ENTRIES * MAX_LINKS;
    localparam int LA_W  = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state               r_state;
    logic                 r_match_dis;
    logic                 r_stopped;
    logic [CNT_W-1:0]     r_count;
    logic [IDX_W-1:0]     r_step;
    logic                 r_found;
    logic [HASH_W-1:0]    r_hash_in;
    logic [SOUND_W-1:0]   r_pair;
    t_outcome             r_res_outcome;
    logic [IDX_W-1:0]     r_res_idx;
    logic [OSLOT_W-1:0]   r_res_slot;
    logic                 r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic [SOUND_W-1:0]   r_link_mem [LINK_DEPTH];

    // cell outputs, one per ring position
    logic [HASH_W-1:0]    w_hash  [MAX_ENTRIES];
    logic [SOUND_W-1:0]   w_sound [MAX_ENTRIES];
    logic [LC_W-1:0]      w_lcnt  [MAX_ENTRIES];

    logic                 w_shift;
    logic                 w_valid_ent;
    logic                 w_hit;
    logic                 w_room;
    logic                 w_inject;
    logic                 w_last;
    logic [HASH_W-1:0]    w_tail_hash;
    logic [SOUND_W-1:0]   w_tail_sound;
    logic [LC_W-1:0]      w_tail_lcnt;
    logic [LA_W-1:0]      w_link_addr;
    logic                 w_link_we;
    logic                 w_out_free;
    logic                 w_cfg_wr;

    // ring of cells: each takes its upper neighbor, the top one takes the tail input
    for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
        if (k == MAX_ENTRIES - 1) begin : g_top
            hdt_cell #(.LC_W(LC_W)) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_hash  (w_tail_hash),
                .i_sound (w_tail_sound),
                .i_lcnt  (w_tail_lcnt),
                .o_hash  (w_hash[k]),
                .o_sound (w_sound[k]),
                .o_lcnt  (w_lcnt[k])
            );
        end else begin : g_mid
            hdt_cell #(.LC_W(LC_W)) u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_hash  (w_hash[k+1]),
                .i_sound (w_sound[k+1]),
                .i_lcnt  (w_lcnt[k+1]),
                .o_hash  (w_hash[k]),
                .o_sound (w_sound[k]),
                .o_lcnt  (w_lcnt[k])
            );
        end
    end

    // head cell holds entry r_step during the rotation
    always_comb begin
        w_shift     = (r_state == S_SEARCH);
        w_valid_ent = CNT_W'(r_step) < r_count;
        w_hit       = w_shift && !r_match_dis && !r_found && w_valid_ent &&
                      (w_hash[0] == r_hash_in);
        w_room      = w_lcnt[0] < LC_W'(MAX_LINKS);
        w_inject    = w_shift && !r_found && (CNT_W'(r_step) == r_count);
        w_last      = (r_step == IDX_W'(MAX_ENTRIES - 1));
        w_link_we   = w_hit && w_room;
        w_link_addr = LA_W'(r_step * MAX_LINKS) + LA_W'(w_lcnt[0]);

        w_tail_hash  = w_hash[0];
        w_tail_sound = w_sound[0];
        w_tail_lcnt  = w_lcnt[0];
        if (w_inject) begin
            w_tail_hash  = r_hash_in;
            w_tail_sound = r_pair;
            w_tail_lcnt  = '0;
        end else if (w_link_we) begin
            w_tail_lcnt  = w_lcnt[0] + 1'b1;
        end

        w_out_free = !r_m_valid || m_axis_tready;
        w_cfg_wr   = psel && penable && pwrite && pready;
    end

    // alias pairs land here; nothing in the result path reads them back
    always_ff @(posedge i_clk) begin
        if (w_link_we) begin
            r_link_mem[w_link_addr] <= r_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_match_dis <= 1'b0;
            r_stopped   <= 1'b0;
            r_count     <= '0;
            r_m_valid   <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            if (w_cfg_wr && (paddr[2] == REG_MATCH_DISABLED)) begin
                r_match_dis <= pwdata[0];
            end

            // drain the result register; in S_DONE the state arm below owns the valid
            if (r_m_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_hash_in  <= s_axis_tdata[HASH_W-1:0];
                        r_pair     <= {s_axis_tdata[HASH_W +: PROG_W],
                                       s_axis_tdata[HASH_W+PROG_W +: NOTE_W]};
                        r_res_idx  <= '0;
                        r_res_slot <= '0;
                        r_step     <= '0;
                        r_found    <= 1'b0;
                        if (r_stopped) begin
                            r_res_outcome <= OUT_REFUSED;
                            r_state       <= S_DONE;
                        end else if (s_axis_tdata[HASH_W-1:0] == '0) begin
                            r_res_outcome <= OUT_SILENT;
                            r_state       <= S_DONE;
                        end else begin
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    r_step <= r_step + 1'b1;
                    if (w_hit) begin
                        r_found   <= 1'b1;
                        r_res_idx <= r_step;
                        if (w_room) begin
                            r_res_outcome <= OUT_ALIAS;
                            r_res_slot    <= OSLOT_W'(w_lcnt[0]);
                        end else begin
                            r_res_outcome <= OUT_DROPPED;
                        end
                    end else if (w_inject) begin
                        r_found       <= 1'b1;
                        r_res_idx     <= r_step;
                        r_res_outcome <= OUT_NEW;
                        r_count       <= r_count + 1'b1;
                    end
                    if (w_last) begin
                        // nothing matched and no free slot: stop for good
                        if (!r_found && !w_hit && !w_inject) begin
                            r_stopped     <= 1'b1;
                            r_res_outcome <= OUT_REFUSED;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= {1'b0, r_res_slot, OIDX_W'(r_res_idx), r_res_outcome};
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_MATCH_DISABLED) ?
                           {{(APB_DW-1){1'b0}}, r_match_dis} : '0;

    `HDT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(MAX_ENTRIES))
    `HDT_ASSERT(a_stop_full, i_clk, i_rst_n, r_stopped |-> (r_count == CNT_W'(MAX_ENTRIES)))
    `HDT_ASSERT(a_inject_count, i_clk, i_rst_n,
        w_inject |=> (r_count == $past(r_count) + 1'b1))
    `HDT_ASSERT(a_rotation_end, i_clk, i_rst_n,
        (r_state == S_SEARCH && w_last) |=> (r_state == S_DONE))
    `HDT_ASSERT_NEVER(a_hit_and_inject, i_clk, i_rst_n, w_hit && w_inject)

endmodule
